// File: design/dps_pkg.sv
package dps_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int PRIO_W      = 16;
    localparam int TIME_W      = 8;
    localparam int STEP_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic [TIME_W-1:0]        TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BUSY      = 2'd1,
        STATUS_ZERO_NEED = 2'd2,
        STATUS_NONE      = 2'd3
    } status_t;

    typedef struct packed {
        logic                     is_tick;
        logic                     bad_slot;
        logic                     zero_need;
        logic [2:0]               slot;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        need;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic                     ran_valid;
        logic [2:0]               ran_slot;
        logic signed [PRIO_W-1:0] ran_priority;
        logic [TIME_W-1:0]        ran_remaining;
        logic [TIME_W-1:0]        ran_used;
        logic                     ran_finished;
        logic                     all_done;
    } res_t;

endpackage

// File: design/dynamic_priority_scheduler_core.sv
// add request: one add per cycle sustained while the result output is not stalled
// tick request: the result follows the one-slot-per-cycle priority scan, and no
// further request leaves the queue until that result is registered
// reset clears all slot active bits, sets priority_step to 3 and empties the queue;
// slot tables are not cleared and hold no meaning until a slot is added
module dynamic_priority_scheduler_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [dps_pkg::STEP_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // process_slot[2:0], start_priority[18:3], need_time[26:19], zero[31:27]
    input  logic [31:0]                s_tdata,
    // command[0]
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // ran_slot[2:0], ran_priority[18:3], ran_remaining[26:19], ran_used[34:27],
    // ran_finished[35], all_done[36], zero[39:37]
    output logic [39:0]                m_tdata,
    // status[1:0], ran_valid[2]
    output logic [2:0]                 m_tuser
);

    dps_pkg::req_t push_data;
    dps_pkg::req_t q_data;
    dps_pkg::res_t res;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    dps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[0]),
        .in_slot   (s_tdata[2:0]),
        .in_prio   (s_tdata[18:3]),
        .in_need   (s_tdata[26:19]),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    dps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    dps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (res)
    );

    assign m_tdata = {3'b000, res.all_done, res.ran_finished, res.ran_used,
                      res.ran_remaining, res.ran_priority, res.ran_slot};
    assign m_tuser = {res.ran_valid, res.status};

endmodule

// File: design/dps_front.sv
module dps_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_cmd,
    input  logic [2:0]     in_slot,
    input  logic [15:0]    in_prio,
    input  logic [7:0]     in_need,
    output logic           push,
    output dps_pkg::req_t  push_data,
    input  logic           q_full
);

    logic          valid_reg;
    logic          valid_next;
    dps_pkg::req_t req_reg;
    dps_pkg::req_t req_next;
    logic          take;

    assign push     = valid_reg && !q_full;
    assign in_ready = !valid_reg || !q_full;
    assign take     = in_valid && in_ready;
    assign push_data = req_reg;

    always_comb begin
        req_next           = req_reg;
        req_next.is_tick   = (in_cmd == dps_pkg::CMD_TICK);
        req_next.bad_slot  = (32'(in_slot) >= dps_pkg::NUM_SLOTS);
        req_next.zero_need = (in_need == '0);
        req_next.slot      = in_slot;
        req_next.prio      = in_prio;
        req_next.need      = in_need;
        valid_next         = take ? 1'b1 : (push ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            req_reg <= req_next;
        end
    end

endmodule

// File: design/dps_queue.sv
module dps_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dps_pkg::req_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output dps_pkg::req_t  q_data
);

    dps_pkg::req_t                 entry_reg [dps_pkg::QUEUE_DEPTH];
    logic [dps_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [dps_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [dps_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [dps_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [dps_pkg::QCNT_W-1:0]    count_reg;
    logic [dps_pkg::QCNT_W-1:0]    count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == dps_pkg::QCNT_W'(dps_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == dps_pkg::QUEUE_DEPTH - 1) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == dps_pkg::QUEUE_DEPTH - 1) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/dps_back.sv
module dps_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [dps_pkg::STEP_W-1:0]  cfg_wr_data,
    input  logic                        q_valid,
    input  dps_pkg::req_t               q_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dps_pkg::res_t               out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    logic signed [dps_pkg::PRIO_W-1:0] prio_tab [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::TIME_W-1:0]        rem_tab  [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::TIME_W-1:0]        used_tab [dps_pkg::NUM_SLOTS];

    state_t                            state_reg;
    state_t                            state_next;
    logic [dps_pkg::NUM_SLOTS-1:0]     active_reg;
    logic [dps_pkg::NUM_SLOTS-1:0]     active_next;
    logic [dps_pkg::STEP_W-1:0]        step_reg;
    logic [dps_pkg::STEP_W-1:0]        step_next;
    logic [dps_pkg::SLOT_W-1:0]        idx_reg;
    logic [dps_pkg::SLOT_W-1:0]        idx_next;
    logic                              found_reg;
    logic                              found_next;
    logic [dps_pkg::SLOT_W-1:0]        best_reg;
    logic [dps_pkg::SLOT_W-1:0]        best_next;
    logic signed [dps_pkg::PRIO_W-1:0] best_prio_reg;
    logic signed [dps_pkg::PRIO_W-1:0] best_prio_next;
    logic [dps_pkg::TIME_W-1:0]        best_rem_reg;
    logic [dps_pkg::TIME_W-1:0]        best_rem_next;
    logic [dps_pkg::TIME_W-1:0]        best_used_reg;
    logic [dps_pkg::TIME_W-1:0]        best_used_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    dps_pkg::res_t                     out_reg;
    dps_pkg::res_t                     out_next;

    logic                              wr_en;
    logic [dps_pkg::SLOT_W-1:0]        wr_addr;
    logic signed [dps_pkg::PRIO_W-1:0] wr_prio;
    logic [dps_pkg::TIME_W-1:0]        wr_rem;
    logic [dps_pkg::TIME_W-1:0]        wr_used;

    logic                              out_free;
    logic [dps_pkg::SLOT_W-1:0]        add_idx;
    logic signed [dps_pkg::PRIO_W-1:0] rd_prio;
    logic signed [dps_pkg::PRIO_W:0]   dec_prio;
    logic signed [dps_pkg::PRIO_W-1:0] new_prio;
    logic [dps_pkg::TIME_W-1:0]        new_rem;
    logic [dps_pkg::TIME_W-1:0]        new_used;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign add_idx   = dps_pkg::SLOT_W'(q_data.slot);
    assign rd_prio   = prio_tab[idx_reg];

    // run one tick on the chosen slot
    assign dec_prio = {best_prio_reg[dps_pkg::PRIO_W-1], best_prio_reg}
                      - $signed({{(dps_pkg::PRIO_W + 1 - dps_pkg::STEP_W){1'b0}}, step_reg});
    assign new_prio = (dec_prio[dps_pkg::PRIO_W] != dec_prio[dps_pkg::PRIO_W-1])
                      ? dps_pkg::PRIO_MIN : dec_prio[dps_pkg::PRIO_W-1:0];
    assign new_rem  = (best_rem_reg != '0) ? best_rem_reg - 1'b1 : best_rem_reg;
    assign new_used = (best_used_reg != dps_pkg::TIME_MAX) ? best_used_reg + 1'b1
                                                           : best_used_reg;

    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        step_next      = cfg_wr_en ? cfg_wr_data : step_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_prio_next = best_prio_reg;
        best_rem_next  = best_rem_reg;
        best_used_next = best_used_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = add_idx;
        wr_prio        = q_data.prio;
        wr_rem         = q_data.need;
        wr_used        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_data.is_tick) begin
                        pop        = 1'b1;
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end else if (out_free) begin
                        pop      = 1'b1;
                        out_next = '0;
                        if (q_data.bad_slot || active_reg[add_idx]) begin
                            out_next.status = dps_pkg::STATUS_BUSY;
                        end else if (q_data.zero_need) begin
                            out_next.status = dps_pkg::STATUS_ZERO_NEED;
                        end else begin
                            out_next.status      = dps_pkg::STATUS_OK;
                            wr_en                = 1'b1;
                            active_next[add_idx] = 1'b1;
                        end
                        out_next.all_done = (active_next == '0);
                        out_valid_next    = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (active_reg[idx_reg] && (!found_reg || rd_prio > best_prio_reg)) begin
                    found_next     = 1'b1;
                    best_next      = idx_reg;
                    best_prio_next = rd_prio;
                    best_rem_next  = rem_tab[idx_reg];
                    best_used_next = used_tab[idx_reg];
                end
                if (idx_reg == dps_pkg::SLOT_W'(dps_pkg::NUM_SLOTS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next = '0;
                    if (!found_reg) begin
                        out_next.status = dps_pkg::STATUS_NONE;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = best_reg;
                        wr_prio  = new_prio;
                        wr_rem   = new_rem;
                        wr_used  = new_used;
                        if (new_rem == '0) begin
                            active_next[best_reg] = 1'b0;
                        end
                        out_next.status        = dps_pkg::STATUS_OK;
                        out_next.ran_valid     = 1'b1;
                        out_next.ran_slot      = 3'(best_reg);
                        out_next.ran_priority  = new_prio;
                        out_next.ran_remaining = new_rem;
                        out_next.ran_used      = new_used;
                        out_next.ran_finished  = (new_rem == '0);
                    end
                    out_next.all_done = (active_next == '0);
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            step_reg      <= dps_pkg::STEP_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
        end
        best_reg      <= best_next;
        best_prio_reg <= best_prio_next;
        best_rem_reg  <= best_rem_next;
        best_used_reg <= best_used_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prio_tab[wr_addr] <= wr_prio;
            rem_tab[wr_addr]  <= wr_rem;
            used_tab[wr_addr] <= wr_used;
        end
    end

endmodule

// File: tb/dynamic_priority_scheduler_checker.sv
module dynamic_priority_scheduler_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [dps_pkg::STEP_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [31:0]                s_tdata,
    input  logic [0:0]                 s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [39:0]                m_tdata,
    input  logic [2:0]                 m_tuser,
    output int                         fail_count,
    output int                         pending
);

    logic signed [dps_pkg::PRIO_W-1:0] prio_table   [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::TIME_W-1:0]        remain_table [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::TIME_W-1:0]        used_table   [dps_pkg::NUM_SLOTS];
    logic [dps_pkg::NUM_SLOTS-1:0]     active_mask;
    logic [dps_pkg::STEP_W-1:0]        cur_step;
    dps_pkg::res_t                     outcome_q [$];

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic predict_outcome(input logic cmd, input logic [2:0] slot,
                                   input logic signed [dps_pkg::PRIO_W-1:0] prio,
                                   input logic [dps_pkg::TIME_W-1:0] need);
        dps_pkg::res_t r;
        int            best;
        int            np;
        int            i;
        r = '0;
        if (cmd == dps_pkg::CMD_ADD) begin
            if (slot >= dps_pkg::NUM_SLOTS || active_mask[slot]) begin
                r.status = dps_pkg::STATUS_BUSY;
            end else if (need == '0) begin
                r.status = dps_pkg::STATUS_ZERO_NEED;
            end else begin
                prio_table[slot]   = prio;
                remain_table[slot] = need;
                used_table[slot]   = '0;
                active_mask[slot]  = 1'b1;
                r.status = dps_pkg::STATUS_OK;
            end
        end else begin
            best = -1;
            for (i = 0; i < dps_pkg::NUM_SLOTS; i++) begin
                if (active_mask[i] && (best < 0 || prio_table[i] > prio_table[best])) begin
                    best = i;
                end
            end
            if (best < 0) begin
                r.status = dps_pkg::STATUS_NONE;
            end else begin
                // saturate at the priority floor
                np = int'(prio_table[best]) - int'(cur_step);
                if (np < int'(dps_pkg::PRIO_MIN)) begin
                    np = int'(dps_pkg::PRIO_MIN);
                end
                prio_table[best] = dps_pkg::PRIO_W'(np);
                if (used_table[best] < dps_pkg::TIME_MAX) begin
                    used_table[best]++;
                end
                if (remain_table[best] > '0) begin
                    remain_table[best]--;
                end
                if (remain_table[best] == '0) begin
                    active_mask[best] = 1'b0;
                end
                r.status        = dps_pkg::STATUS_OK;
                r.ran_valid     = 1'b1;
                r.ran_slot      = 3'(best);
                r.ran_priority  = prio_table[best];
                r.ran_remaining = remain_table[best];
                r.ran_used      = used_table[best];
                r.ran_finished  = !active_mask[best];
            end
        end
        r.all_done = (active_mask == '0);
        outcome_q = {outcome_q, r};
    endtask

    always @(posedge aclk) begin
        dps_pkg::res_t exp_r;
        dps_pkg::res_t got;
        if (!aresetn) begin
            active_mask = '0;
            cur_step    = dps_pkg::STEP_RESET;
            outcome_q.delete();
        end else begin
            if (cfg_wr_en) begin
                cur_step = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                got.status        = dps_pkg::status_t'(m_tuser[1:0]);
                got.ran_valid     = m_tuser[2];
                got.ran_slot      = m_tdata[2:0];
                got.ran_priority  = m_tdata[18:3];
                got.ran_remaining = m_tdata[26:19];
                got.ran_used      = m_tdata[34:27];
                got.ran_finished  = m_tdata[35];
                got.all_done      = m_tdata[36];
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected result: expected none, actual status %0d",
                             $time, got.status);
                end else begin
                    exp_r = outcome_q.pop_front();
                    check_field("status", exp_r.status, got.status);
                    check_field("ran_valid", exp_r.ran_valid, got.ran_valid);
                    check_field("ran_slot", exp_r.ran_slot, got.ran_slot);
                    check_field("ran_priority", exp_r.ran_priority, got.ran_priority);
                    check_field("ran_remaining", exp_r.ran_remaining, got.ran_remaining);
                    check_field("ran_used", exp_r.ran_used, got.ran_used);
                    check_field("ran_finished", exp_r.ran_finished, got.ran_finished);
                    check_field("all_done", exp_r.all_done, got.all_done);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_outcome(s_tuser[0], s_tdata[2:0], s_tdata[18:3], s_tdata[26:19]);
            end
        end
        pending <= outcome_q.size();
    end

endmodule

// File: tb/tb_dynamic_priority_scheduler_core.sv
module tb_dynamic_priority_scheduler_core;

    localparam int NUM_PHASES        = 5;
    localparam int RANDOM_STEP_PHASE = 3;
    localparam int PRESSURE_PHASE    = 4;
    localparam int ITEMS_PER_PHASE   = 170;
    localparam int HOLD_CYCLES       = 300;
    localparam int DRAIN_CYCLES      = dps_pkg::NUM_SLOTS + 8;
    localparam int LIMIT_TIME        = 3000000;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [dps_pkg::STEP_W-1:0] cfg_wr_data;
    logic                       s_tvalid;
    logic                       s_tready;
    // process_slot[2:0], start_priority[18:3], need_time[26:19], zero[31:27]
    logic [31:0]                s_tdata;
    // command[0]
    logic [0:0]                 s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    // ran_slot[2:0], ran_priority[18:3], ran_remaining[26:19], ran_used[34:27],
    // ran_finished[35], all_done[36], zero[39:37]
    logic [39:0]                m_tdata;
    // status[1:0], ran_valid[2]
    logic [2:0]                 m_tuser;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_seq       = 0;
    int sent_count     = 0;
    int directed_count = 0;

    dynamic_priority_scheduler_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    dynamic_priority_scheduler_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Verification failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_taken) begin
                hold_taken = hold_seq;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [2:0] slot,
                                input logic signed [dps_pkg::PRIO_W-1:0] prio,
                                input logic [dps_pkg::TIME_W-1:0] need);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, need, prio, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(input logic [dps_pkg::STEP_W-1:0] step);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= step;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int                                phase;
        int                                n;
        int                                pick;
        logic                              cmd;
        logic [2:0]                        slot;
        logic signed [dps_pkg::PRIO_W-1:0] prio;
        logic [dps_pkg::TIME_W-1:0]        need;
        logic [dps_pkg::STEP_W-1:0]        phase_step [NUM_PHASES];
        int                                phase_send_idle [NUM_PHASES];
        int                                phase_recv_stall [NUM_PHASES];

        phase_step       = '{4'd0, 4'd15, 4'd1, 4'd0, 4'd7};
        phase_send_idle  = '{0, 67, 0, 7, 0};
        phase_recv_stall = '{0, 0, 67, 7, 0};
        phase_step[RANDOM_STEP_PHASE] = dps_pkg::STEP_W'($urandom_range(15));

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset step
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_ADD, 3'd0, 16'sh7fff, 8'd1);
        send_request(dps_pkg::CMD_ADD, 3'd0, 16'sh0005, 8'd3);
        // busy wins over zero need
        send_request(dps_pkg::CMD_ADD, 3'd0, 16'sh0005, 8'd0);
        send_request(dps_pkg::CMD_ADD, 3'd1, 16'sh0005, 8'd0);
        send_request(dps_pkg::CMD_ADD, 3'd3, 16'sh7fff, 8'd2);
        send_request(dps_pkg::CMD_ADD, 3'd7, dps_pkg::PRIO_MIN, 8'd255);
        // tie at the top, lowest slot first
        send_request(dps_pkg::CMD_TICK, 3'd7, 16'shffff, 8'hff);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        // floor saturation
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_ADD, 3'd5, 16'sh8001, 8'd1);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_ADD, 3'd2, 16'sh0000, 8'd1);
        send_request(dps_pkg::CMD_ADD, 3'd4, 16'sh0000, 8'd1);
        send_request(dps_pkg::CMD_ADD, 3'd6, 16'sh0000, 8'd1);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_TICK, 3'd0, 16'sh0000, 8'd0);
        send_request(dps_pkg::CMD_ADD, 3'd1, 16'sh1234, 8'd4);
        send_request(dps_pkg::CMD_TICK, 3'd5, 16'sh5555, 8'haa);
        directed_count = sent_count;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_step(phase_step[phase]);
            send_idle_pct  = phase_send_idle[phase];
            recv_stall_pct = phase_recv_stall[phase];
            if (phase == PRESSURE_PHASE) begin
                hold_seq++;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd  = ($urandom_range(99) < 55) ? dps_pkg::CMD_TICK : dps_pkg::CMD_ADD;
                slot = $urandom_range(7);
                pick = $urandom_range(99);
                if (pick < 40) begin
                    // small set of priorities to force ties
                    prio = dps_pkg::PRIO_W'($urandom_range(3));
                end else if (pick < 50) begin
                    prio = $urandom_range(1)
                           ? dps_pkg::PRIO_W'(16'h7fff - $urandom_range(20))
                           : dps_pkg::PRIO_W'(16'h8000 + $urandom_range(20));
                end else begin
                    prio = dps_pkg::PRIO_W'($urandom);
                end
                pick = $urandom_range(99);
                if (cmd == dps_pkg::CMD_TICK) begin
                    need = dps_pkg::TIME_W'($urandom);
                end else if (pick < 6) begin
                    need = '0;
                end else begin
                    need = dps_pkg::TIME_W'($urandom_range(1, 12));
                end
                send_request(cmd, slot, prio, need);
            end
        end

        wait_drained();
        $display("run covered %0d requests (%0d directed) over %0d priority_step settings",
                 sent_count, directed_count, NUM_PHASES + 1);
        $display("phases mixed sender gaps and result stalls, with one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
